FILE: sv/fdyee_pkg.sv
// Types, codes and the saturation helper shared by the Yee-grid engine
package fdyee_pkg;

	localparam int QW = 32;         // Q16.16 word
	localparam int PW = 49;         // product with 16 fraction bits dropped
	localparam int SW = 51;         // exact sum of up to three products
	localparam int CELL_IDX_W = 6;
	localparam int CFG_IDX_W = 1;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_H_COEF = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_CELL = 1'b1;

	typedef logic signed [QW-1:0] q_t;

	typedef struct packed {
		q_t e;
		q_t h;
	} fld_t;

	typedef struct packed {
		q_t cs;
		q_t cc;
		q_t cj;
	} coef_t;

	typedef struct packed {
		logic shift_fld;
		logic shift_coef;
		logic load;
	} cell_ctl_t;

	// one cell entering the E update
	typedef struct packed {
		logic vld;
		logic first;
		logic interior;
		logic src_hit;
		logic dummy;
	} feed_t;

	// one cell leaving the E update
	typedef struct packed {
		logic vld;
		logic first;
		logic keep_h;
		q_t   e;
		q_t   h;
	} ebeat_t;

	function automatic q_t sat_q(input logic signed [SW-1:0] v);
		q_t r;
		if ((&v[SW-1:QW-1]) || !(|v[SW-1:QW-1])) begin
			r = v[QW-1:0];
		end else if (v[SW-1]) begin
			r = {1'b1, {(QW-1){1'b0}}};
		end else begin
			r = {1'b0, {(QW-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

FILE: sv/fdyee_cell.sv
// One grid cell of the shift chain: E/H fields and the three E coefficients
module fdyee_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fdyee_pkg::cell_ctl_t ctl,
	input  fdyee_pkg::fld_t      nxt_fld,
	input  fdyee_pkg::coef_t     nxt_coef,
	input  fdyee_pkg::fld_t      ld_fld,
	input  fdyee_pkg::coef_t     ld_coef,
	output fdyee_pkg::fld_t      fld_q,
	output fdyee_pkg::coef_t     coef_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fld_q <= '0;
		end else begin
			priority if (ctl.load) begin
				fld_q <= ld_fld;
			end else if (ctl.shift_fld) begin
				fld_q <= nxt_fld;
			end else begin
				fld_q <= fld_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			coef_q <= ld_coef;
		end else if (ctl.shift_coef) begin
			coef_q <= nxt_coef;
		end else begin
			coef_q <= coef_q;
		end
	end

endmodule

FILE: sv/fdyee_eupd.sv
// E-field update pipeline: H difference, three products, sum and saturate
module fdyee_eupd (
	input  logic              clk,
	input  logic              arst_n,
	input  fdyee_pkg::feed_t  feed,
	input  fdyee_pkg::fld_t   fld,
	input  fdyee_pkg::coef_t  coef,
	input  fdyee_pkg::q_t     src,
	output fdyee_pkg::ebeat_t beat
);
	import fdyee_pkg::*;

	q_t                    h_prev_q;
	feed_t                 feed_s1;
	feed_t                 feed_s2;
	q_t                    e_s1;
	q_t                    h_s1;
	logic signed [QW:0]    dh_s1;
	coef_t                 coef_s1;
	q_t                    e_s2;
	q_t                    h_s2;
	logic signed [PW-1:0]  pself_s2;
	logic signed [PW-1:0]  pcurl_s2;
	logic signed [PW-1:0]  psrc_s2;
	logic signed [2*QW-1:0] p_self;
	logic signed [2*QW:0]   p_curl;
	logic signed [2*QW-1:0] p_src;
	logic signed [SW-1:0]   e_sum;

	assign p_self = coef_s1.cs * e_s1;
	assign p_curl = coef_s1.cc * dh_s1;
	assign p_src  = coef_s1.cj * src;
	assign e_sum  = SW'(pself_s2) - SW'(pcurl_s2) - SW'(psrc_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_s1 <= '0;
			feed_s2 <= '0;
			beat    <= '0;
		end else begin
			feed_s1     <= feed;
			feed_s2     <= feed_s1;
			beat.vld    <= feed_s2.vld;
			beat.first  <= feed_s2.first;
			beat.keep_h <= feed_s2.dummy;
			beat.e      <= feed_s2.interior ? sat_q(e_sum) : e_s2;
			beat.h      <= h_s2;
		end
	end

	always_ff @(posedge clk) begin
		// hold the old H of the cell just fed for the next cell's difference
		if (feed.vld) begin
			h_prev_q <= fld.h;
		end
		e_s1     <= fld.e;
		h_s1     <= fld.h;
		dh_s1    <= {fld.h[QW-1], fld.h} - {h_prev_q[QW-1], h_prev_q};
		coef_s1  <= coef;
		e_s2     <= e_s1;
		h_s2     <= h_s1;
		pself_s2 <= PW'($signed(p_self[2*QW-1:16]));
		pcurl_s2 <= $signed(p_curl[2*QW:16]);
		psrc_s2  <= feed_s1.src_hit ? PW'($signed(p_src[2*QW-1:16])) : '0;
	end

endmodule

FILE: sv/fdyee_hupd.sv
// H-field update pipeline: new E difference, product with h_coef, saturate
module fdyee_hupd (
	input  logic              clk,
	input  logic              arst_n,
	input  fdyee_pkg::ebeat_t beat,
	input  fdyee_pkg::q_t     h_coef,
	output fdyee_pkg::fld_t   wb,
	output logic              wb_vld
);
	import fdyee_pkg::*;

	q_t                   e_prev_q;
	q_t                   h_prev_q;
	logic                 vld_s4;
	logic                 keep_s4;
	logic                 vld_s5;
	logic                 keep_s5;
	q_t                   e_s4;
	q_t                   h_s4;
	logic signed [QW:0]   de_s4;
	q_t                   e_s5;
	q_t                   h_s5;
	logic signed [PW-1:0] ph_s5;
	logic signed [2*QW:0] p_h;
	logic signed [SW-1:0] h_sum;

	assign p_h    = h_coef * de_s4;
	assign h_sum  = SW'(h_s5) - SW'(ph_s5);
	assign wb.e   = e_s5;
	assign wb.h   = keep_s5 ? h_s5 : sat_q(h_sum);
	assign wb_vld = vld_s5;

	// each beat finishes the cell before it, whose new E is held here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4  <= 1'b0;
			keep_s4 <= 1'b0;
			vld_s5  <= 1'b0;
			keep_s5 <= 1'b0;
		end else begin
			vld_s4  <= beat.vld && !beat.first;
			keep_s4 <= beat.keep_h;
			vld_s5  <= vld_s4;
			keep_s5 <= keep_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (beat.vld) begin
			e_prev_q <= beat.e;
			h_prev_q <= beat.h;
		end
		de_s4 <= {beat.e[QW-1], beat.e} - {e_prev_q[QW-1], e_prev_q};
		e_s4  <= e_prev_q;
		h_s4  <= h_prev_q;
		e_s5  <= e_s4;
		h_s5  <= h_s4;
		ph_s5 <= $signed(p_h[2*QW:16]);
	end

endmodule

FILE: sv/fdtd_1d_yee_step.sv
// Top level of the one-dimensional FDTD Yee-grid engine
//
// Input channel (in_valid/in_ready): mode 0 loads one cell's E coefficients
// and its E and H values; mode 1 runs one time step with the
// given source sample. Configuration writes (cfg_wr_en) set h_coef and
// source_cell and are taken in any cycle.
// The grid lives in a chain of CELLS cells. A step shifts the chain past one
// E update pipe and one H update pipe and writes the results back into the
// tail. The new E row then leaves on the output channel, cell 0 first, one
// cell per accepted item, last flagged on cell CELLS-1, by rotating the chain
// once.
// One item is in work at a time: in_ready is high only while the block
// is idle.
// A stall on out_ready holds the chain and the current result.
// Reset clears all E and H values, h_coef to 0 and source_cell to 1.
// Coefficients are undefined until loaded.
module fdtd_1d_yee_step #(
	parameter int CELLS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [fdyee_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fdyee_pkg::QW-1:0]            cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                mode,
	input  logic [fdyee_pkg::CELL_IDX_W-1:0]    cell_index,
	input  fdyee_pkg::q_t                       e_coef_self,
	input  fdyee_pkg::q_t                       e_coef_curl,
	input  fdyee_pkg::q_t                       e_coef_src,
	input  fdyee_pkg::q_t                       e_init,
	input  fdyee_pkg::q_t                       h_init,
	input  fdyee_pkg::q_t                       source_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [fdyee_pkg::CELL_IDX_W-1:0]    out_cell,
	output fdyee_pkg::q_t                       e_value,
	output logic                                last
);
	import fdyee_pkg::*;

	localparam int CW        = $clog2(CELLS);
	localparam int STEP_LAST = CELLS + 5;
	localparam int CNT_W     = $clog2(STEP_LAST + 1);
	localparam int CMP_W     = (CNT_W > CELL_IDX_W) ? CNT_W : CELL_IDX_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_STEP = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CW-1:0]           ecnt_q;
	q_t                      h_coef_q;
	logic [CELL_IDX_W-1:0]   source_cell_q;
	q_t                      src_q;

	logic                    in_acc;
	logic                    step_go;
	logic                    load_go;
	logic                    shift_fld;
	logic                    shift_coef;
	logic                    interior;
	feed_t                   feed;
	ebeat_t                  beat;
	fld_t                    wb_fld;
	logic                    wb_vld;
	fld_t                    tail_fld;
	fld_t                    ld_fld;
	coef_t                   ld_coef;
	cell_ctl_t               ctl_a     [CELLS];
	fld_t                    fld_a     [CELLS];
	coef_t                   coef_a    [CELLS];
	fld_t                    nxt_fld_a [CELLS];
	coef_t                   nxt_coef_a[CELLS];

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign step_go  = in_acc && (mode == MODE_STEP);
	assign load_go  = in_acc && (mode == MODE_LOAD);

	assign out_valid = (state_q == S_EMIT);
	assign out_cell  = CELL_IDX_W'(ecnt_q);
	assign e_value   = fld_a[0].e;
	assign last      = (ecnt_q == CW'(CELLS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			ecnt_q        <= '0;
			h_coef_q      <= '0;
			source_cell_q <= CELL_IDX_W'(1);
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_H_COEF:      h_coef_q <= $signed(cfg_data);
					REG_SOURCE_CELL: source_cell_q <= cfg_data[CELL_IDX_W-1:0];
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (step_go) begin
						state_q <= S_STEP;
						cnt_q   <= '0;
					end
				end
				S_STEP: begin
					if (cnt_q == CNT_W'(STEP_LAST)) begin
						state_q <= S_EMIT;
						ecnt_q  <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (out_ready) begin
						if (ecnt_q == CW'(CELLS - 1)) begin
							state_q <= S_IDLE;
						end else begin
							ecnt_q <= ecnt_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			src_q <= source_sample;
		end
	end

	// feed cells 0..CELLS-1, then one extra beat to finish the last cell's H
	assign interior = (cnt_q != '0) && (cnt_q < CNT_W'(CELLS - 1));
	always_comb begin
		feed.vld      = (state_q == S_STEP) && (cnt_q <= CNT_W'(CELLS));
		feed.first    = (cnt_q == '0);
		feed.interior = interior;
		feed.src_hit  = interior && (CMP_W'(cnt_q) == CMP_W'(source_cell_q));
		feed.dummy    = (cnt_q == CNT_W'(CELLS));
	end

	// the field chain shifts every step cycle; coefficients rotate exactly once
	assign shift_fld  = (state_q == S_STEP) || ((state_q == S_EMIT) && out_ready);
	assign shift_coef = (state_q == S_STEP) && (cnt_q < CNT_W'(CELLS));
	assign tail_fld   = wb_vld ? wb_fld : fld_a[0];

	assign ld_fld  = '{e: e_init, h: h_init};
	assign ld_coef = '{cs: e_coef_self, cc: e_coef_curl, cj: e_coef_src};

	for (genvar p = 0; p < CELLS; p++) begin : g_cell
		if (p == CELLS - 1) begin : g_tail
			assign nxt_fld_a[p]  = tail_fld;
			assign nxt_coef_a[p] = coef_a[0];
		end else begin : g_body
			assign nxt_fld_a[p]  = fld_a[p+1];
			assign nxt_coef_a[p] = coef_a[p+1];
		end

		assign ctl_a[p] = '{
			shift_fld:  shift_fld,
			shift_coef: shift_coef,
			load:       load_go && (cell_index == CELL_IDX_W'(p))
		};

		fdyee_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl_a[p]),
			.nxt_fld  (nxt_fld_a[p]),
			.nxt_coef (nxt_coef_a[p]),
			.ld_fld   (ld_fld),
			.ld_coef  (ld_coef),
			.fld_q    (fld_a[p]),
			.coef_q   (coef_a[p])
		);
	end

	fdyee_eupd u_eupd (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed),
		.fld    (fld_a[0]),
		.coef   (coef_a[0]),
		.src    (src_q),
		.beat   (beat)
	);

	fdyee_hupd u_hupd (
		.clk    (clk),
		.arst_n (arst_n),
		.beat   (beat),
		.h_coef (h_coef_q),
		.wb     (wb_fld),
		.wb_vld (wb_vld)
	);

endmodule

FILE: sv/fdyee_chk.sv
// Port-level checks for the Yee-grid engine and their binding to the top
module fdyee_chk #(
	parameter int CELLS = 64
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             mode,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [fdyee_pkg::CELL_IDX_W-1:0] out_cell,
	input fdyee_pkg::q_t                    e_value,
	input logic                             last
);
	import fdyee_pkg::*;

	// never take an item while results are still going out
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while results pending");

	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (mode == MODE_STEP) |=> !in_ready && !out_valid)
		else $error("step item did not occupy the block");

	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=>
			out_valid && (out_cell == $past(out_cell) + 1'b1))
		else $error("row not emitted in cell order");

	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=>
			in_ready && !out_valid && ($past(out_cell) == CELL_IDX_W'(CELLS - 1)))
		else $error("row did not end on the final cell");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_cell) && $stable(e_value))
		else $error("stalled result changed");

endmodule

bind fdtd_1d_yee_step fdyee_chk #(.CELLS(CELLS)) u_fdyee_chk (.*);

FILE: dv/tb_fdtd_1d_yee_step.sv
// Testbench for the 1D FDTD Yee-grid engine: random loads and time steps checked against a predictor
`timescale 1ns / 1ps

module tb_fdtd_1d_yee_step;
	import fdyee_pkg::*;

	localparam int CELLS = 64;
	localparam q_t Q_MAX = 32'sh7FFF_FFFF;
	localparam q_t Q_MIN = 32'sh8000_0000;
	localparam q_t Q_ONE = 32'sh0001_0000;

	typedef struct {
		logic                  mode;
		logic [CELL_IDX_W-1:0] cidx;
		q_t                    cs;
		q_t                    cc;
		q_t                    cj;
		q_t                    e0;
		q_t                    h0;
		q_t                    j;
	} yee_item_t;

	typedef struct {
		logic [CELL_IDX_W-1:0] cidx;
		q_t                    e;
		logic                  lst;
	} e_beat_t;

	class yee_scoreboard;
		q_t                    e_row[CELLS];
		q_t                    h_row[CELLS];
		q_t                    cs_mem[CELLS];
		q_t                    cc_mem[CELLS];
		q_t                    cj_mem[CELLS];
		q_t                    h_coef;
		logic [CELL_IDX_W-1:0] src_cell;
		e_beat_t               row_q[$];
		int                    errors;

		function new();
			foreach (e_row[i]) begin
				e_row[i] = '0;
				h_row[i] = '0;
				cs_mem[i] = '0;
				cc_mem[i] = '0;
				cj_mem[i] = '0;
			end
			h_coef = '0;
			src_cell = CELL_IDX_W'(1);
			errors = 0;
		endfunction

		function int pending();
			return row_q.size();
		endfunction

		task report_mismatch(input string msg);
			errors++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [QW-1:0] data);
			if (idx == REG_H_COEF) begin
				h_coef = q_t'(data);
			end else if (idx == REG_SOURCE_CELL) begin
				src_cell = data[CELL_IDX_W-1:0];
			end
		endfunction

		// exact product, 16 fraction bits dropped toward minus infinity
		function longint fx_mul(input longint a, input longint b);
			longint p;
			p = a * b;
			return p >>> 16;
		endfunction

		function q_t clamp_q(input longint v);
			if (v > longint'(Q_MAX)) begin
				return Q_MAX;
			end else if (v < longint'(Q_MIN)) begin
				return Q_MIN;
			end
			return q_t'(v);
		endfunction

		function void note_item(input yee_item_t it);
			longint acc;
			e_beat_t b;
			if (it.mode == MODE_LOAD) begin
				if (it.cidx < CELLS) begin
					cs_mem[it.cidx] = it.cs;
					cc_mem[it.cidx] = it.cc;
					cj_mem[it.cidx] = it.cj;
					e_row[it.cidx] = it.e0;
					h_row[it.cidx] = it.h0;
				end
				return;
			end
			for (int x = 1; x < CELLS - 1; x++) begin
				acc = fx_mul(cs_mem[x], e_row[x]);
				acc -= fx_mul(cc_mem[x], longint'(h_row[x]) - longint'(h_row[x-1]));
				if (x == int'(src_cell)) begin
					acc -= fx_mul(cj_mem[x], it.j);
				end
				e_row[x] = clamp_q(acc);
			end
			for (int x = 0; x < CELLS - 1; x++) begin
				acc = longint'(h_row[x])
					- fx_mul(h_coef, longint'(e_row[x+1]) - longint'(e_row[x]));
				h_row[x] = clamp_q(acc);
			end
			for (int x = 0; x < CELLS; x++) begin
				b.cidx = CELL_IDX_W'(x);
				b.e = e_row[x];
				b.lst = (x == CELLS - 1);
				row_q.push_back(b);
			end
		endfunction

		task check_beat(input logic [CELL_IDX_W-1:0] got_cidx, input q_t e, input logic lst);
			e_beat_t w;
			if (row_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result cell %0d e %h", got_cidx, e));
				return;
			end
			w = row_q.pop_front();
			if (got_cidx !== w.cidx) begin
				report_mismatch($sformatf("out_cell %0d, want %0d", got_cidx, w.cidx));
			end
			if (e !== w.e) begin
				report_mismatch($sformatf("cell %0d e_value %h, want %h", w.cidx, e, w.e));
			end
			if (lst !== w.lst) begin
				report_mismatch($sformatf("cell %0d last %b, want %b", w.cidx, lst, w.lst));
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [QW-1:0]         cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  mode;
	logic [CELL_IDX_W-1:0] cell_index;
	q_t                    e_coef_self;
	q_t                    e_coef_curl;
	q_t                    e_coef_src;
	q_t                    e_init;
	q_t                    h_init;
	q_t                    source_sample;
	logic                  out_valid;
	logic                  out_ready;
	logic [CELL_IDX_W-1:0] out_cell;
	q_t                    e_value;
	logic                  last;

	yee_scoreboard field_board = new();
	bit                    quiet_phase = 1'b0;
	int                    results_seen = 0;

	fdtd_1d_yee_step #(
		.CELLS(CELLS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.cell_index   (cell_index),
		.e_coef_self  (e_coef_self),
		.e_coef_curl  (e_coef_curl),
		.e_coef_src   (e_coef_src),
		.e_init       (e_init),
		.h_init       (h_init),
		.source_sample(source_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_cell     (out_cell),
		.e_value      (e_value),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#48_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic q_t rand_q();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 5))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return '0;
					3: return -1;
					4: return Q_ONE;
					default: return -Q_ONE;
				endcase
			end
			1, 2, 3: return q_t'($urandom);
			// mostly values within +-4.0 so the grid does not sit at the rails
			default: return q_t'(int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
		endcase
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 15) == 0) begin
			return $urandom_range(10, 40);
		end
		return $urandom_range(1, 3);
	endfunction

	function automatic yee_item_t random_item(input logic m);
		yee_item_t it;
		it.mode = m;
		it.cidx = CELL_IDX_W'($urandom_range(0, CELLS - 1));
		it.cs = rand_q();
		it.cc = rand_q();
		it.cj = rand_q();
		it.e0 = rand_q();
		it.h0 = rand_q();
		it.j = rand_q();
		return it;
	endfunction

	task automatic send_item(input yee_item_t it);
		int n;
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= it.mode;
		cell_index <= it.cidx;
		e_coef_self <= it.cs;
		e_coef_curl <= it.cc;
		e_coef_src <= it.cj;
		e_init <= it.e0;
		h_init <= it.h0;
		source_sample <= it.j;
		do @(posedge clk); while (!in_ready);
		if (!quiet_phase && $urandom_range(0, 1)) begin
			n = gap_len();
			repeat (n) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
	endtask

	task automatic send_load(input int c, input q_t cs, input q_t cc, input q_t cj,
			input q_t e0, input q_t h0);
		yee_item_t it;
		it = random_item(MODE_LOAD);
		it.cidx = CELL_IDX_W'(c);
		it.cs = cs;
		it.cc = cc;
		it.cj = cj;
		it.e0 = e0;
		it.h0 = h0;
		send_item(it);
	endtask

	task automatic send_step(input q_t j);
		yee_item_t it;
		it = random_item(MODE_STEP);
		it.j = j;
		send_item(it);
	endtask

	// drop valid and let the block run dry before touching registers
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (field_board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [QW-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		field_board.set_reg(idx, data);
	endtask

	task automatic set_source(input int c);
		write_reg(REG_SOURCE_CELL, ($urandom & ~32'h3F) | c);
	endtask

	// load bursts followed by a step, with a few lone items mixed in
	task automatic random_phase(input int quota);
		int n;
		int k;
		n = 0;
		while (n < quota) begin
			if ($urandom_range(0, 7) == 0) begin
				send_item(random_item(1'($urandom_range(0, 1))));
				n++;
			end else begin
				k = $urandom_range(0, 3);
				repeat (k) send_item(random_item(MODE_LOAD));
				send_item(random_item(MODE_STEP));
				n += k + 1;
			end
		end
	endtask

	always @(posedge clk) begin : monitor
		yee_item_t seen;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen.mode = mode;
				seen.cidx = cell_index;
				seen.cs = e_coef_self;
				seen.cc = e_coef_curl;
				seen.cj = e_coef_src;
				seen.e0 = e_init;
				seen.h0 = h_init;
				seen.j = source_sample;
				field_board.note_item(seen);
			end
			if (out_valid && out_ready) begin
				field_board.check_beat(out_cell, e_value, last);
				results_seen++;
			end
		end
	end

	// receiver: random stalls, and one long hold-off to back the block up
	initial begin
		int stall_left;
		bit held_off;
		stall_left = 0;
		held_off = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!held_off && results_seen >= 1000) begin
				held_off = 1'b1;
				stall_left = 600;
				out_ready <= 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
				stall_left = gap_len() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int waited;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_LOAD;
		cell_index = '0;
		e_coef_self = '0;
		e_coef_curl = '0;
		e_coef_src = '0;
		e_init = '0;
		h_init = '0;
		source_sample = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill every cell so no step reads an unwritten coefficient
		for (int c = 0; c < CELLS; c++) begin
			send_item(random_item(MODE_LOAD));
		end
		for (int c = 0; c < CELLS; c++) begin
			send_load(c, rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
		end

		// reset register values
		send_step('0);
		send_step(Q_MAX);
		send_step(Q_MIN);
		send_load(0, rand_q(), rand_q(), rand_q(), Q_MAX, Q_MIN);
		send_load(CELLS - 1, rand_q(), rand_q(), rand_q(), Q_MIN, Q_MAX);
		send_load(1, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
		send_load(2, -1, -1, -1, -1, -1);
		send_load(3, '0, '0, '0, '0, '0);
		send_step(Q_MIN);
		send_step(Q_MAX);

		// source at an end cell: no injection
		wait_idle();
		write_reg(REG_H_COEF, Q_MAX);
		set_source(0);
		send_step(Q_MAX);
		send_step(Q_MIN);

		wait_idle();
		write_reg(REG_H_COEF, Q_MIN);
		set_source(CELLS - 1);
		send_step(Q_MAX);
		send_step(-1);

		// last interior cell
		wait_idle();
		write_reg(REG_H_COEF, Q_ONE);
		set_source(CELLS - 2);
		send_load(CELLS - 2, Q_ONE, Q_ONE, Q_MAX, '0, '0);
		send_step(Q_MIN);
		send_step(Q_MAX);

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			quiet_phase = (p == 2);
			write_reg(REG_H_COEF, (p == 4) ? Q_MIN : rand_q());
			set_source($urandom_range(0, CELLS - 1));
			random_phase(36);
		end
		quiet_phase = 1'b0;

		@(negedge clk);
		in_valid <= 1'b0;
		waited = 0;
		while (field_board.pending() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (CELLS + 16) @(posedge clk);
		if (field_board.pending() != 0) begin
			field_board.report_mismatch($sformatf("%0d results never arrived",
				field_board.pending()));
		end
		if (field_board.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/fdyee_pkg.sv
sv/fdyee_cell.sv
sv/fdyee_eupd.sv
sv/fdyee_hupd.sv
sv/fdtd_1d_yee_step.sv
sv/fdyee_chk.sv
dv/tb_fdtd_1d_yee_step.sv
